/* src/sih32_pkg.sv */
// Package: selector codes, stage plans and basic hash stage functions.
`default_nettype none
package sih32_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned SelW   = 10;
  localparam int unsigned NStage = 4;

  // Basic function ids (4 bits); zero means the stage passes its key through.
  typedef logic [3:0] fn_id_t;
  localparam fn_id_t FN_PASS  = 4'd0;
  localparam fn_id_t FN_IDENT = 4'd1;
  localparam fn_id_t FN_SHIFT6 = 4'd2;
  localparam fn_id_t FN_MULT  = 4'd3;
  localparam fn_id_t FN_CONST6 = 4'd5;
  localparam fn_id_t FN_NEG   = 4'd6;
  localparam fn_id_t FN_X61A  = 4'd7;
  localparam fn_id_t FN_SEVEN = 4'd8;
  localparam fn_id_t FN_X61B  = 4'd9;
  localparam fn_id_t FN_SUBX  = 4'd10;
  localparam fn_id_t FN_HALF  = 4'd11;
  localparam fn_id_t FN_CONST5 = 4'd12;
  localparam fn_id_t FN_DB4   = 4'd13;
  localparam fn_id_t FN_DB3   = 4'd14;

  localparam logic [SelW-1:0] SEL_BASIC_LO = 10'd1;
  localparam logic [SelW-1:0] SEL_BASIC_HI = 10'd14;
  localparam logic [SelW-1:0] SEL_TRI_LO  = 10'd101;
  localparam logic [SelW-1:0] SEL_TRI_HI  = 10'd112;
  localparam logic [SelW-1:0] SEL_QUAD_LO = 10'd1001;
  localparam logic [SelW-1:0] SEL_QUAD_HI = 10'd1012;
  localparam logic [SelW-1:0] SEL_RESET   = 10'd1;
  localparam logic [SelW-1:0] SEL_RSVD    = 10'd4;

  localparam logic [0:0] REG_HASH_SELECT = 1'b0;

  typedef struct packed {
    fn_id_t [NStage-1:0] fn;   // fn[0] applied first
    logic                bad;
  } plan_t;

  typedef logic [KeyW-1:0] word_t;

  // Decode the selector into four stage ids (patterns list fn[2] or fn[3] first).
  function automatic plan_t decode_sel(input logic [SelW-1:0] sel);
    plan_t p;
    logic [3:0] ix;
    p.bad = 1'b0;
    p.fn  = '{FN_PASS, FN_PASS, FN_PASS, FN_PASS};
    ix    = 4'd0;
    if (sel >= SEL_BASIC_LO && sel <= SEL_BASIC_HI && sel != SEL_RSVD) begin
      p.fn[0] = fn_id_t'(sel[3:0]);
    end else if (sel >= SEL_TRI_LO && sel <= SEL_TRI_HI) begin
      ix = 4'(sel - SEL_TRI_LO);
      case (ix)
        4'd0:  p.fn[2:0] = '{FN_MULT, FN_SEVEN, FN_CONST6};
        4'd1:  p.fn[2:0] = '{FN_CONST6, FN_CONST5, FN_X61B};
        4'd2:  p.fn[2:0] = '{FN_SHIFT6, FN_X61A, FN_DB3};
        4'd3:  p.fn[2:0] = '{FN_HALF, FN_NEG, FN_CONST5};
        4'd4:  p.fn[2:0] = '{FN_SEVEN, FN_NEG, FN_MULT};
        4'd5:  p.fn[2:0] = '{FN_X61B, FN_SHIFT6, FN_HALF};
        4'd6:  p.fn[2:0] = '{FN_DB4, FN_CONST6, FN_SUBX};
        4'd7:  p.fn[2:0] = '{FN_DB3, FN_HALF, FN_SEVEN};
        4'd8:  p.fn[2:0] = '{FN_NEG, FN_DB3, FN_SHIFT6};
        4'd9:  p.fn[2:0] = '{FN_X61A, FN_DB4, FN_X61A};
        4'd10: p.fn[2:0] = '{FN_SUBX, FN_X61B, FN_DB4};
        4'd11: p.fn[2:0] = '{FN_CONST5, FN_CONST6, FN_NEG};
        default: p.bad = 1'b1;
      endcase
    end else if (sel >= SEL_QUAD_LO && sel <= SEL_QUAD_HI) begin
      ix = 4'(sel - SEL_QUAD_LO);
      case (ix)
        4'd0:  p.fn = '{FN_HALF, FN_CONST5, FN_DB3, FN_DB4};
        4'd1:  p.fn = '{FN_X61A, FN_SHIFT6, FN_CONST5, FN_HALF};
        4'd2:  p.fn = '{FN_SEVEN, FN_SUBX, FN_CONST6, FN_NEG};
        4'd3:  p.fn = '{FN_MULT, FN_MULT, FN_X61A, FN_X61B};
        4'd4:  p.fn = '{FN_CONST6, FN_DB4, FN_SEVEN, FN_X61A};
        4'd5:  p.fn = '{FN_SHIFT6, FN_NEG, FN_DB4, FN_DB3};
        4'd6:  p.fn = '{FN_NEG, FN_SEVEN, FN_X61B, FN_SEVEN};
        4'd7:  p.fn = '{FN_SUBX, FN_X61B, FN_X61A, FN_HALF};
        4'd8:  p.fn = '{FN_X61A, FN_HALF, FN_CONST6, FN_MULT};
        4'd9:  p.fn = '{FN_DB3, FN_CONST6, FN_MULT, FN_SHIFT6};
        4'd10: p.fn = '{FN_X61B, FN_X61A, FN_NEG, FN_CONST6};
        4'd11: p.fn = '{FN_DB4, FN_DB3, FN_SHIFT6, FN_SUBX};
        default: p.bad = 1'b1;
      endcase
    end else begin
      p.bad = 1'b1;
    end
    return p;
  endfunction

  // Part A of a basic function: everything before its multiply (or all of it).
  function automatic word_t pre_mul(input fn_id_t fn, input word_t k_in);
    word_t k;
    k = k_in;
    case (fn)
      FN_SHIFT6: begin
        k = k + (k << 12); k = k ^ (k >> 22); k = k + (k << 4); k = k ^ (k >> 9);
        k = k + (k << 10); k = k ^ (k >> 2);  k = k + (k << 7); k = k ^ (k >> 12);
      end
      FN_MULT: k = k >> 3;
      FN_CONST6: begin
        k = (k + 32'h7ed55d16) + (k << 12);
        k = (k ^ 32'hc761c23c) ^ (k >> 19);
        k = (k + 32'h165667b1) + (k << 5);
        k = (k + 32'hd3a2646c) ^ (k << 9);
        k = (k + 32'hfd7046c5) + (k << 3);
        k = (k ^ 32'hb55a4f09) ^ (k >> 16);
      end
      FN_NEG: begin
        k = ~k + (k << 15); k = k ^ (k >> 12); k = k + (k << 2); k = k ^ (k >> 4);
      end
      FN_X61A, FN_X61B: begin
        k = (k ^ 32'd61) ^ (k >> 16); k = k + (k << 3); k = k ^ (k >> 4);
      end
      FN_SEVEN: begin
        k = ~k + (k << 21); k = k ^ (k >> 24);
        k = (k + (k << 3)) + (k << 8); k = k ^ (k >> 14);
        k = (k + (k << 2)) + (k << 4); k = k ^ (k >> 28);
        k = k + (k << 31);
      end
      FN_SUBX: begin
        k = k - (k << 6); k = k ^ (k >> 17); k = k - (k << 9); k = k ^ (k << 4);
        k = k - (k << 3); k = k ^ (k << 10); k = k ^ (k >> 15);
      end
      FN_HALF: begin
        k = k + ~(k << 15); k = k ^ (k >> 10); k = k + (k << 3); k = k ^ (k >> 6);
        k = k + ~(k << 11); k = k ^ (k >> 16);
      end
      FN_CONST5: begin
        k = (k + 32'h479ab41d) + (k << 8);
        k = (k ^ 32'he4aa10ce) ^ (k >> 5);
        k = (k + 32'h9942f0a6) - (k << 14);
        k = (k ^ 32'h5aedd67d) ^ (k >> 3);
        k = (k + 32'h17bea992) + (k << 7);
      end
      FN_DB4: begin
        k = (k ^ 32'hdeadbeef) + (k << 4); k = k ^ (k >> 10);
        k = k + (k << 7); k = k ^ (k >> 13);
      end
      FN_DB3: begin
        k = k ^ (k >> 4); k = (k ^ 32'hdeadbeef) + (k << 5); k = k ^ (k >> 11);
      end
      default: k = k_in;
    endcase
    return k;
  endfunction

  // Multiplier constant of a function; one means no multiply.
  function automatic word_t mul_const(input fn_id_t fn);
    word_t c;
    case (fn)
      FN_MULT:          c = 32'd2654435761;
      FN_NEG:           c = 32'd2057;
      FN_X61A, FN_X61B: c = 32'h27d4eb2d;
      default:          c = 32'd1;
    endcase
    return c;
  endfunction

  // Tail after the multiply.
  function automatic word_t post_mul(input fn_id_t fn, input word_t k);
    word_t r;
    case (fn)
      FN_NEG:           r = k ^ (k >> 16);
      FN_X61A, FN_X61B: r = k ^ (k >> 15);
      default:          r = k;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* src/sih32_stage.sv */
// One hash stage: mix logic, register, multiply and tail, register.
`default_nettype none
module sih32_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                vld_i,
  input  wire sih32_pkg::plan_t    plan_i,
  input  wire sih32_pkg::word_t    k_i,
  input  wire logic [1:0]          idx_i,
  output logic                     vld_o,
  output sih32_pkg::plan_t         plan_o,
  output sih32_pkg::word_t         k_o
);
  import sih32_pkg::*;

  logic   vld_a_r;
  plan_t  plan_a_r;
  word_t  k_a_r;
  word_t  c_a_r;
  logic   vld_b_r;
  plan_t  plan_b_r;
  word_t  k_b_r;
  fn_id_t fn_a;

  assign fn_a = plan_i.fn[idx_i];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      vld_a_r <= vld_i;
      vld_b_r <= vld_a_r;
    end
    plan_a_r <= plan_i;
    k_a_r    <= pre_mul(fn_a, k_i);
    c_a_r    <= mul_const(fn_a);
    plan_b_r <= plan_a_r;
    k_b_r    <= post_mul(plan_a_r.fn[idx_i], word_t'(k_a_r * c_a_r));
  end

  assign vld_o  = vld_b_r;
  assign plan_o = plan_b_r;
  assign k_o    = k_b_r;

endmodule
`default_nettype wire

/* src/selectable_integer_hash32_core.sv */
// Top level: selectable 32-bit integer hash, ten-register pipeline.
//
//  channel | ports                         | handshake
//  input   | in_start, in_busy, in_key     | accepted when in_start & !in_busy
//  result  | out_strobe, out_hash_value,   | one cycle, receiver cannot stall
//          | out_bad_select                |
//  config  | cfg_psel ... cfg_prdata       | APB write on psel&penable&pwrite
//
// One transaction enters every cycle; in_busy is always low.
// Pipeline: selector decode register, then four hash stages
// of two registers each (mix logic, then the 32x32 multiply), then the
// output register. Reset clears valid bits and sets hash_select to 1.
`default_nettype none
module selectable_integer_hash32_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_start,
  output logic                     in_busy,
  input  wire sih32_pkg::word_t    in_key,
  output logic                     out_strobe,
  output sih32_pkg::word_t         out_hash_value,
  output logic                     out_bad_select,
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [1:0]          cfg_paddr,
  input  wire logic [31:0]         cfg_pwdata,
  output logic [31:0]              cfg_prdata,
  output logic                     cfg_pready
);
  import sih32_pkg::*;

  logic [SelW-1:0] sel_r;
  logic            wr_en;

  logic  vld_d_r;
  plan_t plan_d_r;
  word_t key_d_r;

  logic  vld_s   [NStage+1];
  plan_t plan_s  [NStage+1];
  word_t k_s     [NStage+1];

  logic  out_vld_r;
  word_t out_h_r;
  logic  out_bad_r;

  assign cfg_pready = 1'b1;
  assign in_busy    = 1'b0;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // Only register 0 exists at address 0; writes to other addresses are dropped.
  assign cfg_prdata = {{(32-SelW){1'b0}}, sel_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= SEL_RESET;
    end else if (wr_en && cfg_paddr[1:0] == 2'b00) begin
      sel_r <= cfg_pwdata[SelW-1:0];
    end
  end

  // Decode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else begin
      vld_d_r <= in_start && !in_busy;
    end
    plan_d_r <= decode_sel(sel_r);
    key_d_r  <= in_key;
  end

  assign vld_s[0]  = vld_d_r;
  assign plan_s[0] = plan_d_r;
  assign k_s[0]    = key_d_r;

  for (genvar g = 0; g < NStage; g++) begin : g_stage
    sih32_stage u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_s[g]),
      .plan_i (plan_s[g]),
      .k_i    (k_s[g]),
      .idx_i  (2'(g)),
      .vld_o  (vld_s[g+1]),
      .plan_o (plan_s[g+1]),
      .k_o    (k_s[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_s[NStage];
    end
    out_h_r   <= plan_s[NStage].bad ? '0 : k_s[NStage];
    out_bad_r <= plan_s[NStage].bad;
  end

  assign out_strobe     = out_vld_r;
  assign out_hash_value = out_h_r;
  assign out_bad_select = out_bad_r;

  // Bad selector always yields zero hash.
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_bad_select |-> out_hash_value == '0)
    else $error("bad select with nonzero hash");

  // Strobe is set in the cycle after the last stage valid.
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    vld_s[NStage] |=> out_strobe)
    else $error("lost result");

  // Identity selection passes the key through unchanged.
  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    in_start && sel_r == SEL_RESET && !wr_en |=> ##9 out_strobe
      && out_hash_value == $past(in_key, 10))
    else $error("identity mismatch");

endmodule
`default_nettype wire

/* dv/selectable_integer_hash32_core_test.sv */
// Testbench: selectable 32-bit integer hash core against a behavioral predictor.
`timescale 1ns / 100ps
`default_nettype none

class hash_scoreboard;
  logic [31:0] exp_hash[$];
  logic        exp_bad[$];
  int          mismatches;

  function void note_key(input logic [31:0] h, input logic b);
    exp_hash = {exp_hash, h};
    exp_bad  = {exp_bad, b};
  endfunction

  function void check_result(input logic [31:0] h, input logic b);
    logic [31:0] eh;
    logic        eb;
    if (exp_hash.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result hash=%h bad=%b", h, b);
      return;
    end
    eh = exp_hash.pop_front();
    eb = exp_bad.pop_front();
    if (eh !== h || eb !== b) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: exp hash=%h bad=%b, got hash=%h bad=%b", eh, eb, h, b);
    end
  endfunction
endclass

module selectable_integer_hash32_core_test;
  import sih32_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_start = 1'b0;
  logic        in_busy;
  word_t       in_key = '0;
  logic        out_strobe;
  word_t       out_hash_value;
  logic        out_bad_select;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  localparam int LATENCY = 10;
  localparam logic [1:0] ADDR_HASH_SELECT = 2'(REG_HASH_SELECT) << 2;

  hash_scoreboard sb = new();
  logic [9:0] cur_sel;   // predictor's copy of hash_select
  int idle_pct;

  selectable_integer_hash32_core u_top (.*);

  always #10 clk = ~clk;

  // Result monitor: the strobe is sampled at the edge that ends its cycle.
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_result(out_hash_value, out_bad_select);
  end

  // Basic mix functions, numbered by selector code.
  function automatic word_t mix_one(input fn_id_t id, input word_t k_in);
    word_t k;
    k = k_in;
    case (id)
      FN_IDENT: ;
      FN_SHIFT6: begin
        k += k << 12; k ^= k >> 22; k += k << 4; k ^= k >> 9;
        k += k << 10; k ^= k >> 2;  k += k << 7; k ^= k >> 12;
      end
      FN_MULT: k = (k >> 3) * 32'd2654435761;
      FN_CONST6: begin
        k = (k + 32'h7ed55d16) + (k << 12);
        k = (k ^ 32'hc761c23c) ^ (k >> 19);
        k = (k + 32'h165667b1) + (k << 5);
        k = (k + 32'hd3a2646c) ^ (k << 9);
        k = (k + 32'hfd7046c5) + (k << 3);
        k = (k ^ 32'hb55a4f09) ^ (k >> 16);
      end
      FN_NEG: begin
        k = ~k + (k << 15); k ^= k >> 12; k += k << 2; k ^= k >> 4;
        k = k * 32'd2057; k ^= k >> 16;
      end
      FN_X61A, FN_X61B: begin
        k = (k ^ 32'd61) ^ (k >> 16); k += k << 3; k ^= k >> 4;
        k = k * 32'h27d4eb2d; k ^= k >> 15;
      end
      FN_SEVEN: begin
        k = ~k + (k << 21); k ^= k >> 24;
        k = (k + (k << 3)) + (k << 8); k ^= k >> 14;
        k = (k + (k << 2)) + (k << 4); k ^= k >> 28;
        k += k << 31;
      end
      FN_SUBX: begin
        k -= k << 6; k ^= k >> 17; k -= k << 9; k ^= k << 4;
        k -= k << 3; k ^= k << 10; k ^= k >> 15;
      end
      FN_HALF: begin
        k += ~(k << 15); k ^= k >> 10; k += k << 3; k ^= k >> 6;
        k += ~(k << 11); k ^= k >> 16;
      end
      FN_CONST5: begin
        k = (k + 32'h479ab41d) + (k << 8);
        k = (k ^ 32'he4aa10ce) ^ (k >> 5);
        k = (k + 32'h9942f0a6) - (k << 14);
        k = (k ^ 32'h5aedd67d) ^ (k >> 3);
        k = (k + 32'h17bea992) + (k << 7);
      end
      FN_DB4: begin
        k = (k ^ 32'hdeadbeef) + (k << 4); k ^= k >> 10;
        k += k << 7; k ^= k >> 13;
      end
      FN_DB3: begin
        k ^= k >> 4; k = (k ^ 32'hdeadbeef) + (k << 5); k ^= k >> 11;
      end
      default: k = '0;
    endcase
    return k;
  endfunction

  // Expected hash and bad flag for a key under the current selector.
  task automatic predict_hash(input word_t key, output word_t h, output logic bad);
    fn_id_t tri_plan[12][3] = '{
      '{FN_CONST6, FN_SEVEN, FN_MULT}, '{FN_X61B, FN_CONST5, FN_CONST6},
      '{FN_DB3, FN_X61A, FN_SHIFT6},   '{FN_CONST5, FN_NEG, FN_HALF},
      '{FN_MULT, FN_NEG, FN_SEVEN},    '{FN_HALF, FN_SHIFT6, FN_X61B},
      '{FN_SUBX, FN_CONST6, FN_DB4},   '{FN_SEVEN, FN_HALF, FN_DB3},
      '{FN_SHIFT6, FN_DB3, FN_NEG},    '{FN_X61A, FN_DB4, FN_X61A},
      '{FN_DB4, FN_X61B, FN_SUBX},     '{FN_NEG, FN_CONST6, FN_CONST5}};
    fn_id_t quad_plan[12][4] = '{
      '{FN_DB4, FN_DB3, FN_CONST5, FN_HALF},
      '{FN_HALF, FN_CONST5, FN_SHIFT6, FN_X61A},
      '{FN_NEG, FN_CONST6, FN_SUBX, FN_SEVEN},
      '{FN_X61B, FN_X61A, FN_MULT, FN_MULT},
      '{FN_X61A, FN_SEVEN, FN_DB4, FN_CONST6},
      '{FN_DB3, FN_DB4, FN_NEG, FN_SHIFT6},
      '{FN_SEVEN, FN_X61B, FN_SEVEN, FN_NEG},
      '{FN_HALF, FN_X61A, FN_X61B, FN_SUBX},
      '{FN_MULT, FN_CONST6, FN_HALF, FN_X61A},
      '{FN_SHIFT6, FN_MULT, FN_CONST6, FN_DB3},
      '{FN_CONST6, FN_NEG, FN_X61A, FN_X61B},
      '{FN_SUBX, FN_SHIFT6, FN_DB3, FN_DB4}};
    h = key;
    bad = 1'b0;
    if (cur_sel >= SEL_BASIC_LO && cur_sel <= SEL_BASIC_HI && cur_sel != SEL_RSVD) begin
      h = mix_one(fn_id_t'(cur_sel[3:0]), key);
    end else if (cur_sel >= SEL_TRI_LO && cur_sel <= SEL_TRI_HI) begin
      for (int i = 0; i < 3; i++) h = mix_one(tri_plan[cur_sel - SEL_TRI_LO][i], h);
    end else if (cur_sel >= SEL_QUAD_LO && cur_sel <= SEL_QUAD_HI) begin
      for (int i = 0; i < 4; i++) h = mix_one(quad_plan[cur_sel - SEL_QUAD_LO][i], h);
    end else begin
      h = '0;
      bad = 1'b1;
    end
  endtask

  // APB write; upper data bits exercise truncation to 10 bits.
  task automatic write_reg(input logic [1:0] addr, input logic [31:0] data);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1; cfg_paddr = addr; cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_HASH_SELECT) cur_sel = data[9:0];
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
  endtask

  // Drive one key; may idle first. Inputs move on the falling edge.
  task automatic send_key(input word_t key);
    word_t h;
    logic  b;
    while ($urandom_range(99) < idle_pct) begin
      in_start = 1'b0;
      @(negedge clk);
    end
    in_start = 1'b1;
    in_key   = key;
    do @(posedge clk); while (in_busy);
    predict_hash(key, h, b);
    sb.note_key(h, b);
    @(negedge clk);
  endtask

  // Stop sending, let the pipe drain and settle before reconfiguring.
  task automatic drain();
    in_start = 1'b0;
    while (sb.exp_hash.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  function automatic word_t rand_key();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return 32'h1 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  // Mostly valid selectors; some invalid ones including reserved code 4.
  function automatic logic [31:0] rand_sel();
    logic [31:0] hi;
    hi = $urandom() & 32'hffff_fc00;
    case ($urandom_range(9))
      0, 1, 2: return hi | $urandom_range(SEL_BASIC_HI, SEL_BASIC_LO);
      3, 4:    return hi | $urandom_range(SEL_TRI_HI, SEL_TRI_LO);
      5, 6:    return hi | $urandom_range(SEL_QUAD_HI, SEL_QUAD_LO);
      7:       return hi | SEL_RSVD;
      default: return hi | $urandom_range(1023);
    endcase
  endfunction

  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int n;
    cur_sel  = SEL_RESET;
    idle_pct = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: reset selector is identity, then key extremes.
    send_key('0); send_key('1); send_key(32'h8000_0000); send_key(32'h0000_003d);
    drain();
    // Selector codes 0-16, 100-113 and 1000-1023 (incl. 0, reserved 4, edges and 1023) on extreme and random keys.
    for (int s = 0; s <= 1023; s++) begin
      if (s <= 16 || (s >= 100 && s <= 113) || s >= 1000) begin
        write_reg(ADDR_HASH_SELECT, 32'(s));
        send_key('0); send_key('1); send_key($urandom());
        drain();
      end
    end
    // Write with junk above the 10-bit field.
    write_reg(ADDR_HASH_SELECT, 32'hffff_fc00 | SEL_QUAD_HI);
    send_key(32'h1234_5678);
    drain();

    // Random phases: sender idles 24%, then 78%, then never.
    n = 0;
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 24 : (ph == 1) ? 78 : 0;
      for (int seg = 0; seg < 25; seg++) begin
        write_reg(ADDR_HASH_SELECT, rand_sel());
        repeat (20) send_key(rand_key());
        n += 20;
        drain();  // pauses until every expected result is in
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.exp_hash.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire

/* selectable_integer_hash32_core.f */
src/sih32_pkg.sv
src/sih32_stage.sv
src/selectable_integer_hash32_core.sv
dv/selectable_integer_hash32_core_test.sv
